// ===== rtl/core/mbdc_pkg.sv =====
package mbdc_pkg;

  localparam int NUM_BUTTONS_DEF = 9;
  localparam int COUNT_WIDTH_DEF = 16;

  // fixed field widths
  localparam int LEVEL_W = 9;
  localparam int TICKS_W = 16;
  localparam int ID_W    = 4;
  localparam int KIND_W  = 2;

  // register reset values
  localparam logic [TICKS_W-1:0] TICKS_RST        = 16'd30;
  localparam logic [ID_W-1:0]    COMBO_FIRST_RST  = 4'd1;
  localparam logic [ID_W-1:0]    COMBO_SECOND_RST = 4'd7;
  localparam logic [ID_W-1:0]    PAIRING_RST      = 4'd9;

  // register indexes
  localparam logic [1:0] REG_TICKS        = 2'd0;
  localparam logic [1:0] REG_COMBO_FIRST  = 2'd1;
  localparam logic [1:0] REG_COMBO_SECOND = 2'd2;
  localparam logic [1:0] REG_PAIRING      = 2'd3;

  // input operation
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_PRESSED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAIR_BTN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COMBO    = 2'd3;

  typedef struct packed {
    logic              load_edge;
    logic              start;
    logic              dec;
    logic              disarm;
    logic              commit;
    logic              idx_inc;
    logic              push;
    logic              push_combo;
    logic [KIND_W-1:0] push_kind;
    logic              set_latch;
    logic              clr_latch;
    logic              flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic armed;
    logic cnt_gt1;
    logic pressed;
    logic changed;
    logic is_pair;
    logic is_combo_btn;
    logic both;
    logic latched;
    logic held_valid;
    logic out_free;
    logic last_idx;
  } dp_status_t;

endpackage

// ===== rtl/core/mbdc_ctrl.sv =====
module mbdc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_op,
  output logic                   in_ready,
  input  mbdc_pkg::dp_status_t   st,
  output mbdc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_COMBO = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   can_push;
  logic   emit_needed;

  assign can_push    = !st.held_valid || st.out_free;
  assign emit_needed = !st.is_pair || st.pressed;
  assign in_ready    = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == mbdc_pkg::OP_EDGE) begin
            cmd.load_edge = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!st.armed || st.cnt_gt1 || !st.changed) begin
          cmd.dec    = st.armed && st.cnt_gt1;
          cmd.disarm = st.armed && !st.cnt_gt1;
          if (st.last_idx) state_next = S_DONE;
          else cmd.idx_inc = 1'b1;
        end else if (!emit_needed || can_push) begin
          cmd.commit = 1'b1;
          cmd.push   = emit_needed;
          if (st.is_pair) cmd.push_kind = mbdc_pkg::KIND_PAIR_BTN;
          else if (st.pressed) cmd.push_kind = mbdc_pkg::KIND_PRESSED;
          else cmd.push_kind = mbdc_pkg::KIND_RELEASED;
          if (!st.is_pair && st.is_combo_btn) state_next = S_COMBO;
          else if (st.last_idx) state_next = S_DONE;
          else cmd.idx_inc = 1'b1;
        end
      end
      S_COMBO: begin
        // stable state already holds the new level here
        if (st.both && !st.latched) begin
          if (can_push) begin
            cmd.push       = 1'b1;
            cmd.push_combo = 1'b1;
            cmd.push_kind  = mbdc_pkg::KIND_COMBO;
            cmd.set_latch  = 1'b1;
            if (st.last_idx) state_next = S_DONE;
            else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_SCAN;
            end
          end
        end else begin
          cmd.clr_latch = !st.both;
          if (st.last_idx) state_next = S_DONE;
          else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      S_DONE: begin
        if (!st.held_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== rtl/core/mbdc_datapath.sv =====
module mbdc_datapath #(
  parameter int NUM_BUTTONS = mbdc_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = mbdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [mbdc_pkg::TICKS_W-1:0]    cfg_data,
  input  logic [mbdc_pkg::ID_W-1:0]       in_edge,
  input  logic [mbdc_pkg::LEVEL_W-1:0]    in_levels,
  input  mbdc_pkg::ctrl_cmd_t             cmd,
  output mbdc_pkg::dp_status_t            st,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mbdc_pkg::KIND_W-1:0]     out_kind,
  output logic [mbdc_pkg::ID_W-1:0]       out_button,
  output logic                            out_last
);

  localparam int IDX_W  = $clog2(NUM_BUTTONS);
  localparam int CMP_RW = $clog2(NUM_BUTTONS + 1);
  localparam int CMP_W  = (CMP_RW > mbdc_pkg::ID_W) ? CMP_RW : mbdc_pkg::ID_W;
  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  // configuration
  logic [mbdc_pkg::TICKS_W-1:0] ticks;
  logic [mbdc_pkg::ID_W-1:0]    combo_first;
  logic [mbdc_pkg::ID_W-1:0]    combo_second;
  logic [mbdc_pkg::ID_W-1:0]    pairing;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks        <= mbdc_pkg::TICKS_RST;
      combo_first  <= mbdc_pkg::COMBO_FIRST_RST;
      combo_second <= mbdc_pkg::COMBO_SECOND_RST;
      pairing      <= mbdc_pkg::PAIRING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbdc_pkg::REG_TICKS:        ticks        <= cfg_data;
        mbdc_pkg::REG_COMBO_FIRST:  combo_first  <= cfg_data[mbdc_pkg::ID_W-1:0];
        mbdc_pkg::REG_COMBO_SECOND: combo_second <= cfg_data[mbdc_pkg::ID_W-1:0];
        mbdc_pkg::REG_PAIRING:      pairing      <= cfg_data[mbdc_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  // per-button state
  logic [NUM_BUTTONS-1:0]   stable;
  logic [NUM_BUTTONS-1:0]   armed;
  logic [COUNT_WIDTH-1:0]   cnt [NUM_BUTTONS];
  logic                     latched;
  logic [IDX_W-1:0]         idx;
  logic [NUM_BUTTONS-1:0]   levels;

  logic [COUNT_WIDTH-1:0]   load_val;
  logic                     edge_ok;
  logic [IDX_W-1:0]         edge_idx;
  logic [CMP_W-1:0]         edge_ext;
  logic [CMP_W-1:0]         id;
  logic                     pressed;
  logic                     held_first;
  logic                     held_second;

  always_comb begin
    if (ticks == '0) load_val = COUNT_WIDTH'(1);
    else if (33'(ticks) > CNT_MAX) load_val = '1;
    else load_val = COUNT_WIDTH'(ticks);
  end

  assign edge_ext = CMP_W'(in_edge);
  assign edge_ok  = (edge_ext != '0) && (edge_ext <= CMP_W'(NUM_BUTTONS));
  assign edge_idx = IDX_W'(edge_ext - CMP_W'(1));
  assign id       = CMP_W'(idx) + CMP_W'(1);
  assign pressed  = levels[idx];

  // a combo id outside the button range reads as released
  always_comb begin
    held_first  = 1'b0;
    held_second = 1'b0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      if (CMP_W'(combo_first) == CMP_W'(k + 1)) held_first = stable[k];
      if (CMP_W'(combo_second) == CMP_W'(k + 1)) held_second = stable[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable  <= '0;
      armed   <= '0;
      latched <= 1'b0;
    end else begin
      if (cmd.load_edge && edge_ok) armed[edge_idx] <= 1'b1;
      if (cmd.disarm) armed[idx] <= 1'b0;
      if (cmd.commit) begin
        armed[idx]  <= 1'b0;
        stable[idx] <= pressed;
      end
      if (cmd.set_latch) latched <= 1'b1;
      else if (cmd.clr_latch) latched <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && edge_ok) cnt[edge_idx] <= load_val;
    if (cmd.dec) cnt[idx] <= cnt[idx] - COUNT_WIDTH'(1);
    if (cmd.start) levels <= NUM_BUTTONS'(in_levels);
    if (cmd.start) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + IDX_W'(1);
  end

  // event stage: one held event plus the output register, so the last
  // event of a tick can be marked when the scan ends
  logic                        held_valid;
  logic [mbdc_pkg::KIND_W-1:0] held_kind;
  logic [mbdc_pkg::ID_W-1:0]   held_button;
  logic                        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        held_valid <= 1'b0;
      end else if (cmd.push) begin
        held_valid <= 1'b1;
        if (held_valid) out_valid <= 1'b1;
        else if (out_ready) out_valid <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush || (cmd.push && held_valid)) begin
      out_kind   <= held_kind;
      out_button <= held_button;
      out_last   <= cmd.flush;
    end
    if (cmd.push) begin
      held_kind   <= cmd.push_kind;
      held_button <= cmd.push_combo ? '0 : mbdc_pkg::ID_W'(id);
    end
  end

  always_comb begin
    st              = '0;
    st.armed        = armed[idx];
    st.cnt_gt1      = cnt[idx] > COUNT_WIDTH'(1);
    st.pressed      = pressed;
    st.changed      = pressed != stable[idx];
    st.is_pair      = id == CMP_W'(pairing);
    st.is_combo_btn = (id == CMP_W'(combo_first)) || (id == CMP_W'(combo_second));
    st.both         = held_first && held_second;
    st.latched      = latched;
    st.held_valid   = held_valid;
    st.out_free     = out_free;
    st.last_idx     = idx == IDX_W'(NUM_BUTTONS - 1);
  end

endmodule

// ===== rtl/core/multi_button_debounce_combo.sv =====
// Debouncer for a row of buttons with a pairing button and a latched
// two-button pairing combo.
// Input stream (s_*): s_tuser is the operation (0 tick, 1 raw edge).
// An edge transfer re-arms that button's countdown.
// A tick transfer decrements all armed countdowns and samples the levels
// of the buttons that expire, one button per cycle while no event is held
// up by a stalled receiver, with an extra combo check step after a combo
// button changes. The scan walks the buttons through one shared
// compare/decrement path under a small FSM.
// Output stream (m_*): one pressed/released/pairing/combo event per transfer,
// in ascending button order, m_tlast on the final event of a tick.
// An event waits in a hold stage until the next event of the tick, or the
// end of the scan, moves it into the output register. A stalled receiver
// holds the scan only when a new event finds both the output register and
// the hold stage full; at the end of the scan the held event has to move
// out before the next input is taken, which may then overlap its wait.
// Configuration (cfg_*) must be written only while the block is idle; the block itself does not enforce it.
// Reset clears all stable states to released, disarms every countdown,
// clears the combo latch and loads the default registers.
module multi_button_debounce_combo #(
  parameter int NUM_BUTTONS = mbdc_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = mbdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] edge_button, [12:4] button_levels
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] event_button
  output logic [1:0]  m_tuser,   // event_kind
  output logic        m_tlast
);

  mbdc_pkg::ctrl_cmd_t  cmd;
  mbdc_pkg::dp_status_t st;
  logic [mbdc_pkg::ID_W-1:0] out_button;

  mbdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mbdc_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_edge    (s_tdata[3:0]),
    .in_levels  (s_tdata[12:4]),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_button (out_button),
    .out_last   (m_tlast)
  );

  assign m_tdata = {4'b0000, out_button};

endmodule
